// ===== design/imm_pkg.sv =====
package imm_pkg;

    localparam int DEFAULT_MAX_DIM = 8;

    localparam int DIM_W     = 4;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 16;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 35;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

    // A dimension of zero counts as one, and anything above the store size is cut to it.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = 4'd1;
        else if (v > max_dim)
            r = max_dim;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== design/imm_if.sv =====
interface imm_cmd_if;
    import imm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output row, output col, output value,
                    input ready);
    modport sink (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

interface imm_res_if;
    import imm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PROD_W-1:0] product;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     last;
    logic                     size_error;

    modport source (output valid, output product, output out_row, output out_col,
                    output last, output size_error, input ready);
    modport sink (input valid, input product, input out_row, input out_col,
                  input last, input size_error, output ready);
endinterface

interface imm_cfg_if;
    import imm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/imm_ram.sv =====
module imm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/integer_matrix_multiply.sv =====
// A load word (write of an A or B element) is taken whenever the sequencer is idle.
// A compute word yields m*q product elements with dimensions after clamping: each product element
// streams n operand pairs through the two store read ports, then waits for the
// multiply and accumulate stages to drain before it moves to the output register.
// A size mismatch goes to the error state, which loads the error word once the output is free.
// Reset sets all four dimension registers to 8 and idles the sequencer; the stores are not cleared.
module integer_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::DEFAULT_MAX_DIM
) (
    input logic     clk,
    input logic     rst_n,
    imm_cfg_if.sink cfg,
    imm_cmd_if.sink cmd,
    imm_res_if.source res
);
    import imm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIN_W  = 2 * IDX_W + 1;
    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ERR   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DIM_W-1:0] m_reg, n_reg, q_reg, m_next, n_next, q_next;
    logic [DIM_W-1:0] m_c, n_c, p_c, q_c;
    logic [IDX_W-1:0] i_reg, j_reg, k_reg, i_next, j_next, k_next;

    logic                     rd_vld_reg, mul_vld_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [VAL_W-1:0]  a_rd, b_rd;

    logic                     out_valid_reg, out_valid_next;
    logic signed [PROD_W-1:0] out_prod_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic                     out_last_reg, out_err_reg;

    logic cmd_fire, out_free, elem_done, k_last, j_last, i_last, in_range;
    logic issue, load_out, load_err, acc_clr;
    logic we_a, we_b;
    logic [LIN_W-1:0] wr_lin, a_lin, b_lin;

    // Configuration port.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_RESET;
            a_cols_reg <= DIM_RESET;
            b_rows_reg <= DIM_RESET;
            b_cols_reg <= DIM_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_A_ROWS: a_rows_reg <= cfg.data;
                CFG_A_COLS: a_cols_reg <= cfg.data;
                CFG_B_ROWS: b_rows_reg <= cfg.data;
                CFG_B_COLS: b_cols_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign m_c = clamp_dim(a_rows_reg, MAX_D);
    assign n_c = clamp_dim(a_cols_reg, MAX_D);
    assign p_c = clamp_dim(b_rows_reg, MAX_D);
    assign q_c = clamp_dim(b_cols_reg, MAX_D);

    // Operand stores.
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign in_range  = ({1'b0, cmd.row} < MAX_D) && ({1'b0, cmd.col} < MAX_D);
    assign we_a      = cmd_fire && (cmd.op == OP_WRITE_A) && in_range;
    assign we_b      = cmd_fire && (cmd.op == OP_WRITE_B) && in_range;

    assign wr_lin = LIN_W'(cmd.row) * LIN_W'(MAX_DIM) + LIN_W'(cmd.col);
    assign a_lin  = LIN_W'(i_reg) * LIN_W'(MAX_DIM) + LIN_W'(k_reg);
    assign b_lin  = LIN_W'(k_reg) * LIN_W'(MAX_DIM) + LIN_W'(j_reg);

    imm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
        .clk   (clk),
        .we    (we_a),
        .waddr (wr_lin[ADDR_W-1:0]),
        .wdata (cmd.value),
        .raddr (a_lin[ADDR_W-1:0]),
        .rdata (a_rd)
    );

    imm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
        .clk   (clk),
        .we    (we_b),
        .waddr (wr_lin[ADDR_W-1:0]),
        .wdata (cmd.value),
        .raddr (b_lin[ADDR_W-1:0]),
        .rdata (b_rd)
    );

    // Sequencer.
    assign out_free  = !out_valid_reg || res.ready;
    assign elem_done = !rd_vld_reg && !mul_vld_reg;
    assign k_last    = (({1'b0, k_reg}) + 4'd1) == n_reg;
    assign j_last    = (({1'b0, j_reg}) + 4'd1) == q_reg;
    assign i_last    = (({1'b0, i_reg}) + 4'd1) == m_reg;

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        load_out   = 1'b0;
        load_err   = 1'b0;
        acc_clr    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.op == OP_COMPUTE))
                begin
                    m_next  = m_c;
                    n_next  = n_c;
                    q_next  = q_c;
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                    acc_clr = 1'b1;
                    state_next = (n_c != p_c) ? ST_ERR : ST_MAC;
                end
            end
            ST_MAC:
            begin
                issue = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                if (elem_done && out_free)
                begin
                    load_out = 1'b1;
                    acc_clr  = 1'b1;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 3'd1;
                            state_next = ST_MAC;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 3'd1;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    load_err   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out || load_err)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_reg         <= DIM_RESET;
            n_reg         <= DIM_RESET;
            q_reg         <= DIM_RESET;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            mul_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            n_reg         <= n_next;
            q_reg         <= q_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            rd_vld_reg    <= issue;
            mul_vld_reg   <= rd_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Multiply and accumulate stages behind the store read registers.
    always_ff @(posedge clk)
    begin
        mul_reg <= MUL_W'(a_rd) * MUL_W'(b_rd);
        if (acc_clr)
            acc_reg <= '0;
        else if (mul_vld_reg)
            acc_reg <= acc_reg + PROD_W'(mul_reg);

        if (load_out)
        begin
            out_prod_reg <= acc_reg;
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_last_reg <= i_last && j_last;
            out_err_reg  <= 1'b0;
        end
        else if (load_err)
        begin
            out_prod_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_last_reg <= 1'b1;
            out_err_reg  <= 1'b1;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.product    = out_prod_reg;
    assign res.out_row    = out_row_reg;
    assign res.out_col    = out_col_reg;
    assign res.last       = out_last_reg;
    assign res.size_error = out_err_reg;
endmodule

// ===== design/imm_checker.sv =====
module imm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cmd_valid,
    input logic                             cmd_ready,
    input logic [imm_pkg::OP_W-1:0]         cmd_op,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic signed [imm_pkg::PROD_W-1:0] res_product,
    input logic [imm_pkg::IDX_W-1:0]        res_out_row,
    input logic [imm_pkg::IDX_W-1:0]        res_out_col,
    input logic                             res_last,
    input logic                             res_size_error
);
    import imm_pkg::*;

    // A result word waiting on the sink keeps its valid.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_product) && $stable(res_out_row)
            && $stable(res_out_col) && $stable(res_last) && $stable(res_size_error))
        else $error("result payload changed while stalled");

    // A compute word occupies the block, so it cannot take another word right away.
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_op == OP_COMPUTE) |=> !cmd_ready)
        else $error("command taken right after a compute word");

    // New results are produced only while a compute run holds the command side.
    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready))
        else $error("result appeared outside a compute run");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_size_error |-> res_last && (res_product == '0)
            && (res_out_row == '0) && (res_out_col == '0))
        else $error("malformed size error word");
endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_op         (cmd.op),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_product    (res.product),
    .res_out_row    (res.out_row),
    .res_out_col    (res.out_col),
    .res_last       (res.last),
    .res_size_error (res.size_error)
);
